[hdl/max_cut_height_search_top_macros.svh]
// ----------------------------------------------------------------------------
// max_cut_height_search_top_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef MAX_CUT_HEIGHT_SEARCH_TOP_MACROS_SVH
`define MAX_CUT_HEIGHT_SEARCH_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define MCHS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MCHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mchs_pkg.sv]
// ----------------------------------------------------------------------------
// mchs_pkg
// shared widths for the cut height search block and its checker
// ----------------------------------------------------------------------------
package mchs_pkg;

  localparam int REQ_W     = 40;
  localparam int HEIGHT_W  = 30;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 32;

endpackage

[hdl/mchs_ram.sv]
// ----------------------------------------------------------------------------
// mchs_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module mchs_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/max_cut_height_search_top.sv]
// ----------------------------------------------------------------------------
// max_cut_height_search_top
// greatest cut threshold whose summed excess reaches the required amount
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_axis    in         tdata: height [29:0]; tlast: last_item
//  m_axis    out        tdata: best_threshold [29:0]; tuser: none_possible
//  cfg       in         data: required_amount [39:0]
//
//  loading accepts one height per cycle while s_axis_tready is high; each
//  search step makes one pass over the height ram through a single
//  subtract, compare and add unit
//  s_axis_tready is low from the last transaction of a set until its result
//  is placed in the output register; a stalled result holds the search
//  rst is synchronous, active high; the height ram needs no clearing
// ----------------------------------------------------------------------------
module max_cut_height_search_top #(
  parameter int MAX_ITEMS   = 1024,
  parameter int HEIGHT_BITS = 30
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mchs_pkg::S_TDATA_W-1:0] s_axis_tdata,  // height
  input  logic                           s_axis_tlast,  // last_item
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mchs_pkg::M_TDATA_W-1:0] m_axis_tdata,  // best_threshold
  output logic                           m_axis_tuser,  // none_possible
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mchs_pkg::REQ_W-1:0]     cfg_data       // required_amount
);

  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W = HEIGHT_BITS + CNT_W;
  localparam int CMP_W = (SUM_W > mchs_pkg::REQ_W) ? SUM_W : mchs_pkg::REQ_W;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_PASS  = 3'd1;
  localparam logic [2:0] ST_EVAL  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                 state;
  logic [mchs_pkg::REQ_W-1:0] required_amount;
  logic [CNT_W-1:0]           item_count;
  logic [HEIGHT_BITS-1:0]     largest_height;
  logic [CNT_W-1:0]           idx;
  logic                       rd_vld;
  logic [SUM_W-1:0]           excess_sum;
  logic [HEIGHT_BITS-1:0]     thr;
  logic [HEIGHT_BITS:0]       search_low;
  logic [HEIGHT_BITS:0]       search_high;
  logic                       first_pass;
  logic                       none_flag;

  logic                       in_fire;
  logic                       store_full;
  logic [HEIGHT_BITS-1:0]     h_in;
  logic                       rd_en;
  logic [HEIGHT_BITS-1:0]     rd_data;
  logic [HEIGHT_BITS:0]       diff;
  logic [HEIGHT_BITS-1:0]     excess;
  logic                       reached;
  logic [HEIGHT_BITS:0]       mid;

  assign s_axis_tready = (state == ST_LOAD);
  assign cfg_ready     = 1'b1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign store_full    = (item_count == CNT_W'(MAX_ITEMS));
  assign h_in          = HEIGHT_BITS'(s_axis_tdata[mchs_pkg::HEIGHT_W-1:0]);
  assign rd_en         = (state == ST_PASS) && (idx < item_count);

  // shared datapath: excess of one height above the threshold
  assign diff    = {1'b0, rd_data} - {1'b0, thr};
  assign excess  = diff[HEIGHT_BITS] ? '0 : diff[HEIGHT_BITS-1:0];
  assign reached = CMP_W'(excess_sum) >= CMP_W'(required_amount);
  assign mid     = search_low + ((search_high - search_low + 1'b1) >> 1);

  mchs_ram #(
    .WIDTH(HEIGHT_BITS),
    .DEPTH(MAX_ITEMS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (in_fire && !store_full),
    .wr_addr(item_count[AW-1:0]),
    .wr_data(h_in),
    .rd_en  (rd_en),
    .rd_addr(idx[AW-1:0]),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      required_amount <= '0;
    end else if (cfg_valid && cfg_ready) begin
      required_amount <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_LOAD;
      item_count     <= '0;
      largest_height <= '0;
      idx            <= '0;
      rd_vld         <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      excess_sum     <= '0;
      thr            <= '0;
      search_low     <= '0;
      search_high    <= '0;
      first_pass     <= 1'b0;
      none_flag      <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if ((state == ST_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (!store_full) begin
              item_count <= item_count + 1'b1;
              if (h_in > largest_height) begin
                largest_height <= h_in;
              end
            end
            if (s_axis_tlast) begin
              state      <= ST_PASS;
              thr        <= '0;
              first_pass <= 1'b1;
              excess_sum <= '0;
              idx        <= '0;
            end
          end
        end
        ST_PASS: begin
          if (rd_en) begin
            idx <= idx + 1'b1;
          end
          if (rd_vld) begin
            excess_sum <= excess_sum + SUM_W'(excess);
          end else if (idx == item_count) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (first_pass) begin
            first_pass <= 1'b0;
            if (!reached) begin
              none_flag <= 1'b1;
              state     <= ST_DONE;
            end else begin
              search_low  <= '0;
              search_high <= {1'b0, largest_height};
              state       <= ST_CHECK;
            end
          end else begin
            if (reached) begin
              search_low <= {1'b0, thr};
            end else begin
              search_high <= {1'b0, thr} - 1'b1;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (search_low < search_high) begin
            thr        <= mid[HEIGHT_BITS-1:0];
            excess_sum <= '0;
            idx        <= '0;
            state      <= ST_PASS;
          end else begin
            none_flag <= 1'b0;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            item_count     <= '0;
            largest_height <= '0;
            state          <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tuser <= none_flag;
      if (none_flag) begin
        m_axis_tdata <= '0;
      end else begin
        m_axis_tdata <= mchs_pkg::M_TDATA_W'(mchs_pkg::HEIGHT_W'(search_low));
      end
    end
  end

endmodule

[hdl/mchs_checker.sv]
// ----------------------------------------------------------------------------
// mchs_checker
// port-level checks for the cut height search block
// ----------------------------------------------------------------------------
`include "max_cut_height_search_top_macros.svh"

module mchs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mchs_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  // stalled result holds
  `MCHS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // a failed search reports threshold zero
  `MCHS_ASSERT_SAME(a_none_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "none_possible with nonzero threshold")

  // closing a set starts the search, input side blocked
  `MCHS_ASSERT_NEXT(a_last_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input ready right after last transaction")

  // a new result comes out together with the return to loading
  `MCHS_ASSERT_SAME(a_out_ready, $rose(m_axis_tvalid), s_axis_tready, "result raised while still searching")

  `MCHS_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind max_cut_height_search_top mchs_checker u_mchs_checker (.*);
